@@ hw/rtl/frame_time_stability_monitor_top_assert.svh @@
// ----------------------------------------------------------------------------
// frame_time_stability_monitor_top_assert.svh
// Assertion macros shared by the checker of the frame time monitor.
// ----------------------------------------------------------------------------
`ifndef FRAME_TIME_STABILITY_MONITOR_TOP_ASSERT_SVH
`define FRAME_TIME_STABILITY_MONITOR_TOP_ASSERT_SVH

// Consequent checked in the clock after the antecedent.
`define FTSM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent checked in the same clock as the antecedent.
`define FTSM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/ftsm_pkg.sv @@
// ----------------------------------------------------------------------------
// ftsm_pkg
// Types and constants of the frame time stability monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package ftsm_pkg;

    localparam int HISTORY_DEPTH_DEF = 60;
    localparam int FRAME_W           = 20;
    localparam int DROP_W            = 8;
    localparam int SAMPLES_W         = 6;
    localparam int MCAND_W           = 24;   // holds target * 11
    localparam int IN_TDATA_W        = 24;
    localparam int OUT_TDATA_W       = 40;
    localparam int MIN_SAMPLES       = 10;

    localparam logic [FRAME_W-1:0] TARGET_RESET    = 20'd16670;
    localparam logic [DROP_W-1:0]  MAX_DROPS_RESET = 8'd3;
    localparam logic [DROP_W-1:0]  DROP_SAT        = 8'hFF;

    // register select: paddr[2]
    localparam logic REG_TARGET    = 1'b0;
    localparam logic REG_MAX_DROPS = 1'b1;

    typedef enum logic {
        MODE_RECORD = 1'b0,
        MODE_CLEAR  = 1'b1
    } t_mode;

endpackage

`default_nettype wire

@@ hw/rtl/frame_time_stability_monitor_top.sv @@
// ----------------------------------------------------------------------------
// frame_time_stability_monitor_top
// Sliding window frame time monitor with drop run and stability verdict.
// ----------------------------------------------------------------------------
// Each request on the input stream records one frame time (tuser = 0) or
// clears the window and drop run (tuser = 1), and yields exactly one result.
// The last HISTORY_DEPTH frame times sit in a RAM ring with a running sum.
// A request steps through EVICT, START, RUN and EMIT, where RUN holds
// while the bit-serial divider producing the average, one quotient bit
// per cycle over the window sum, runs. A new request is taken while a
// finished result still waits on the output. Registers: 0x0 target frame
// time (us, 20 bit), 0x4 largest drop run still judged stable (8 bit).
`default_nettype none

module frame_time_stability_monitor_top #(
    parameter int HISTORY_DEPTH = ftsm_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [2:0]                         paddr,
    input  wire logic [31:0]                        pwdata,
    output logic      [31:0]                        prdata,
    output logic                                    pready,
    // input stream
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    input  wire logic [ftsm_pkg::IN_TDATA_W-1:0]    i_s_tdata,  // [19:0] frame_time_us
    input  wire logic [0:0]                         i_s_tuser,  // [0] mode
    // result stream
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // [19:0] average_frame_time_us, [27:20] consecutive_drop_count,
    // [28] frame_dropped, [29] rate_stable, [35:30] samples_held
    output logic      [ftsm_pkg::OUT_TDATA_W-1:0]   o_m_tdata
);

    localparam int FRAME_W = ftsm_pkg::FRAME_W;
    localparam int DROP_W  = ftsm_pkg::DROP_W;
    localparam int SMP_W   = ftsm_pkg::SAMPLES_W;
    localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int SLOT_W  = $clog2(HISTORY_DEPTH);
    localparam int SUM_W   = FRAME_W + CNT_W;
    localparam int P_W     = ftsm_pkg::MCAND_W + CNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVICT,
        ST_START,
        ST_RUN,
        ST_EMIT
    } t_state;

    t_state                r_state;
    logic [FRAME_W-1:0]    r_target;
    logic [DROP_W-1:0]     r_max_drops;
    logic [SLOT_W-1:0]     r_slot;
    logic [SLOT_W-1:0]     r_wr_addr;
    logic [CNT_W-1:0]      r_fill;
    logic [SUM_W-1:0]      r_sum;
    logic [DROP_W-1:0]     r_drop_run;
    logic                  r_dropped;
    logic                  r_evict;
    logic                  r_record;
    logic [FRAME_W-1:0]    r_frame;
    logic [P_W-1:0]        r_lhs;
    logic                  r_m_valid;
    logic [ftsm_pkg::OUT_TDATA_W-1:0] r_m_data;

    logic                  w_accept;
    logic                  w_cfg_wr;
    logic                  w_is_clear;
    logic [FRAME_W-1:0]    w_frame;
    logic [FRAME_W+1:0]    w_three_target;
    logic [FRAME_W+1:0]    w_two_frame;
    logic                  w_drop;
    logic [DROP_W-1:0]     n_drop_run;
    logic                  w_full;
    logic                  w_slot_last;
    logic [FRAME_W-1:0]    w_old;
    logic [ftsm_pkg::MCAND_W-1:0] w_mcand;
    logic [P_W-1:0]        w_lhs;
    logic                  w_done;
    logic [SUM_W-1:0]      w_quo;
    logic [P_W-1:0]        w_prod;
    logic [FRAME_W-1:0]    w_avg;
    logic                  w_stable;
    logic [CNT_W+SMP_W-1:0] w_fill_ext;
    logic                  w_out_free;

    always_comb begin
        w_accept       = i_s_tvalid && o_s_tready;
        w_cfg_wr       = psel && penable && pwrite && pready;
        w_is_clear     = (ftsm_pkg::t_mode'(i_s_tuser[0]) == ftsm_pkg::MODE_CLEAR);
        w_frame        = i_s_tdata[FRAME_W-1:0];
        // drop test: 2*frame > 3*target
        w_three_target = {2'b00, r_target} + {1'b0, r_target, 1'b0};
        w_two_frame    = {1'b0, w_frame, 1'b0};
        w_drop         = (w_two_frame > w_three_target);
        if (!w_drop) begin
            n_drop_run = '0;
        end else if (r_drop_run == ftsm_pkg::DROP_SAT) begin
            n_drop_run = r_drop_run;
        end else begin
            n_drop_run = r_drop_run + DROP_W'(1);
        end
        w_full      = (r_fill == CNT_W'(HISTORY_DEPTH));
        w_slot_last = (r_slot == SLOT_W'(HISTORY_DEPTH - 1));
        w_mcand     = {1'b0, r_target, 3'b000} + {3'b000, r_target, 1'b0}
                    + {4'b0000, r_target};
        w_lhs       = {1'b0, r_sum, 3'b000} + {3'b000, r_sum, 1'b0};
        w_avg       = (r_fill == '0) ? '0 : w_quo[FRAME_W-1:0];
        w_stable    = (r_fill < CNT_W'(ftsm_pkg::MIN_SAMPLES))
                    || ((r_lhs <= w_prod) && (r_drop_run <= r_max_drops));
        w_fill_ext  = {{SMP_W{1'b0}}, r_fill};
        w_out_free  = !r_m_valid || i_m_tready;
    end

    // history ring: old entry read on accept, new entry written in the EVICT state that follows
    ftsm_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    ((r_state == ST_EVICT) && r_record),
        .i_waddr (r_wr_addr),
        .i_wdata (r_frame),
        .i_re    (w_accept),
        .i_raddr (r_slot),
        .o_rdata (w_old)
    );

    ftsm_serial_unit #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_serial (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == ST_START),
        .i_dividend (r_sum),
        .i_divisor  (r_fill),
        .i_mcand    (w_mcand),
        .o_done     (w_done),
        .o_quotient (w_quo),
        .o_product  (w_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_target    <= ftsm_pkg::TARGET_RESET;
            r_max_drops <= ftsm_pkg::MAX_DROPS_RESET;
            r_slot      <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_drop_run  <= '0;
            r_dropped   <= 1'b0;
            r_evict     <= 1'b0;
            r_record    <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                case (paddr[2])
                    ftsm_pkg::REG_TARGET:    r_target    <= pwdata[FRAME_W-1:0];
                    ftsm_pkg::REG_MAX_DROPS: r_max_drops <= pwdata[DROP_W-1:0];
                    default: ;
                endcase
            end
            // EMIT reloads the output register on its own
            if (r_m_valid && i_m_tready && (r_state != ST_EMIT)) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_EVICT;
                        if (w_is_clear) begin
                            r_slot     <= '0;
                            r_fill     <= '0;
                            r_sum      <= '0;
                            r_drop_run <= '0;
                            r_dropped  <= 1'b0;
                            r_evict    <= 1'b0;
                            r_record   <= 1'b0;
                        end else begin
                            r_record   <= 1'b1;
                            r_frame    <= w_frame;
                            r_wr_addr  <= r_slot;
                            r_evict    <= w_full;
                            r_sum      <= r_sum + SUM_W'(w_frame);
                            r_slot     <= w_slot_last ? '0 : r_slot + SLOT_W'(1);
                            r_drop_run <= n_drop_run;
                            r_dropped  <= w_drop;
                            if (!w_full) begin
                                r_fill <= r_fill + CNT_W'(1);
                            end
                        end
                    end
                end
                ST_EVICT: begin
                    if (r_evict) begin
                        r_sum <= r_sum - SUM_W'(w_old);
                    end
                    r_state <= ST_START;
                end
                ST_START: begin
                    r_lhs   <= w_lhs;
                    r_state <= ST_RUN;
                end
                ST_RUN: begin
                    if (w_done) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {4'b0000, w_fill_ext[SMP_W-1:0], w_stable,
                                      r_dropped, r_drop_run, w_avg};
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            ftsm_pkg::REG_TARGET:    prdata = {12'd0, r_target};
            ftsm_pkg::REG_MAX_DROPS: prdata = {24'd0, r_max_drops};
            default:                 prdata = '0;
        endcase
    end

    assign pready     = 1'b1;
    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

`default_nettype wire

@@ hw/rtl/ftsm_ram.sv @@
// ----------------------------------------------------------------------------
// ftsm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ftsm_ram #(
    parameter int WIDTH = ftsm_pkg::FRAME_W,
    parameter int DEPTH = ftsm_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ftsm_serial_unit.sv @@
// ----------------------------------------------------------------------------
// ftsm_serial_unit
// Bit-serial restoring divider (sum / count) with a shift-add multiplier
// (target*11 * count) running alongside, one bit per clock.
// ----------------------------------------------------------------------------
`default_nettype none

module ftsm_serial_unit #(
    parameter int HISTORY_DEPTH = ftsm_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic                                             i_clk,
    input  wire logic                                             i_rst_n,
    input  wire logic                                             i_start,
    input  wire logic [ftsm_pkg::FRAME_W+$clog2(HISTORY_DEPTH+1)-1:0] i_dividend,
    input  wire logic [$clog2(HISTORY_DEPTH+1)-1:0]               i_divisor,
    input  wire logic [ftsm_pkg::MCAND_W-1:0]                     i_mcand,
    output logic                                                  o_done,
    output logic [ftsm_pkg::FRAME_W+$clog2(HISTORY_DEPTH+1)-1:0]  o_quotient,
    output logic [ftsm_pkg::MCAND_W+$clog2(HISTORY_DEPTH+1)-1:0]  o_product
);

    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W  = ftsm_pkg::FRAME_W + CNT_W;
    localparam int P_W    = ftsm_pkg::MCAND_W + CNT_W;
    localparam int STEP_W = $clog2(SUM_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [SUM_W-1:0]  r_quo;     // dividend bits leave at the top, quotient enters below
    logic [P_W-1:0]    r_mcand;
    logic [CNT_W-1:0]  r_mplier;
    logic [P_W-1:0]    r_acc;

    logic [CNT_W:0]    w_trial;
    logic              w_fits;
    logic [CNT_W:0]    n_rem;
    logic [P_W-1:0]    n_acc;

    always_comb begin
        w_trial = {r_rem, r_quo[SUM_W-1]};
        w_fits  = (w_trial >= {1'b0, r_div});
        n_rem   = w_fits ? (w_trial - {1'b0, r_div}) : w_trial;
        n_acc   = r_mplier[0] ? (r_acc + r_mcand) : r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy   <= 1'b1;
                r_step   <= STEP_W'(SUM_W - 1);
                r_rem    <= '0;
                r_div    <= i_divisor;
                r_quo    <= i_dividend;
                r_mcand  <= P_W'(i_mcand);
                r_mplier <= i_divisor;
                r_acc    <= '0;
            end else if (r_busy) begin
                r_rem    <= n_rem[CNT_W-1:0];
                r_quo    <= {r_quo[SUM_W-2:0], w_fits};
                r_acc    <= n_acc;
                r_mcand  <= {r_mcand[P_W-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[CNT_W-1:1]};
                r_step   <= r_step - STEP_W'(1);
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
    assign o_product  = r_acc;

endmodule

`default_nettype wire

@@ hw/rtl/ftsm_checker.sv @@
// ----------------------------------------------------------------------------
// ftsm_checker
// Port-level checks of the frame time monitor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_time_stability_monitor_top_assert.svh"

module ftsm_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_s_tvalid,
    input wire logic                             o_s_tready,
    input wire logic                             o_m_tvalid,
    input wire logic                             i_m_tready,
    input wire logic [ftsm_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    logic       w_in_req;
    logic       w_out_stall;
    logic       w_dropped;
    logic [7:0] w_run;

    assign w_in_req    = i_s_tvalid && o_s_tready;
    assign w_out_stall = o_m_tvalid && !i_m_tready;
    assign w_dropped   = o_m_tdata[28];
    assign w_run       = o_m_tdata[27:20];

    // one request in flight at a time
    `FTSM_ASSERT_NEXT(a_one_in_flight, w_in_req, !o_s_tready, "request taken while busy")

    // a dropped frame always leaves a nonzero drop run (it saturates at 8'hFF)
    `FTSM_ASSERT_NOW(a_drop_has_run, o_m_tvalid && w_dropped, w_run != 8'd0, "empty drop run")

    // a good frame or a clear ends the drop run
    `FTSM_ASSERT_NOW(a_good_ends_run, o_m_tvalid && !w_dropped, w_run == 8'd0, "run kept")

    `FTSM_ASSERT_NEXT(a_held, w_out_stall, o_m_tvalid && $stable(o_m_tdata), "result changed")

endmodule

bind frame_time_stability_monitor_top ftsm_checker u_ftsm_checker (.*);

`default_nettype wire
